// ----- src/su3mv_pkg.sv -----
// su3mv_pkg: shared types and register codes for the su3 matrix-vector multiply
// item payload structs, pipeline enable bundle, configuration register indexes
// no dependencies
package su3mv_pkg;

  // packed complex words: bits 63:32 real, 31:0 imag
  typedef struct packed {
    logic [63:0] link_00;
    logic [63:0] link_01;
    logic [63:0] link_02;
    logic [63:0] link_10;
    logic [63:0] link_11;
    logic [63:0] link_12;
    logic [63:0] link_20;
    logic [63:0] link_21;
    logic [63:0] link_22;
    logic [63:0] vec_0;
    logic [63:0] vec_1;
    logic [63:0] vec_2;
  } su3mv_in_t;

  typedef struct packed {
    logic [63:0] res_0;
    logic [63:0] res_1;
    logic [63:0] res_2;
    logic        batch_end;
  } su3mv_out_t;

  // stage load enables, stage 1 is the input register in the top level
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } su3mv_ctrl_t;

  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 24;
  localparam int SiteW     = 24;

  localparam logic [CfgIdxW-1:0] CFG_CONJ_TRANSPOSE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_BATCH_LENGTH   = 1'd1;

endpackage

// ----- src/su3_matrix_vector_multiply.sv -----
// su3_matrix_vector_multiply: top level, link times vector or its conjugate transpose
// input register, three lanes, merge and output register, batch site counter
// depends on su3mv_pkg, su3mv_lane, su3mv_sat
//
//   port group   direction  handshake          payload
//   in_          in         in_valid/in_ready  su3mv_in_t  (link and vector)
//   out_         out        out_valid/out_ready su3mv_out_t (result, batch end)
//   cfg_         in         cfg_we             cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready stays high; an accepted item passes
// five registers: input, products, column terms, column sum, saturated output
// each stage loads when empty or when the stage after it moves, so a stalled output
// still lets items fill the bubbles upstream; in_ready falls only when all are full
// synchronous active-low reset clears stage valids, site counter and conjugate flag, sets batch length to one
module su3_matrix_vector_multiply
  import su3mv_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS   = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  su3mv_in_t           in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output su3mv_out_t          out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int AccW = 2 * CW + 3;
  localparam int NStg = 5;

  logic              conj_r;
  logic [SiteW-1:0]  blen_r;
  logic [SiteW-1:0]  site_r;
  logic [SiteW-1:0]  site_nxt;
  logic              be_nxt;
  logic [SiteW:0]    site_inc;
  logic [NStg-1:0]   vld_r;
  logic [NStg-1:0]   en;
  logic [NStg-2:0]   be_r;
  logic              accept;
  su3mv_ctrl_t       ctrl;

  logic [63:0]          lk [9];
  logic [63:0]          vw [3];
  logic signed [CW-1:0] sel_re_nxt [3][3];
  logic signed [CW-1:0] sel_im_nxt [3][3];
  logic signed [CW-1:0] lr_r [3][3];
  logic signed [CW-1:0] li_r [3][3];
  logic signed [CW-1:0] vr_r [3];
  logic signed [CW-1:0] vi_r [3];
  logic                 s1_conj_r;
  logic signed [AccW-1:0] sum_re [3];
  logic signed [AccW-1:0] sum_im [3];

  // stage enables, from the output back to the input
  always_comb begin
    en[NStg-1] = !vld_r[NStg-1] || out_ready;
    for (int s = NStg - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign accept    = in_valid && in_ready;
  assign out_valid = vld_r[NStg-1];

  always_comb begin
    ctrl.en2 = en[1];
    ctrl.en3 = en[2];
    ctrl.en4 = en[3];
    ctrl.en5 = en[4];
  end

  // stage valids and batch end marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int s = 1; s < NStg; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      be_r[0] <= be_nxt;
    end
    for (int s = 1; s < NStg - 1; s++) begin
      if (en[s]) begin
        be_r[s] <= be_r[s-1];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conj_r <= 1'b0;
      blen_r <= SiteW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONJ_TRANSPOSE: conj_r <= cfg_wdata[0];
        CFG_BATCH_LENGTH:   blen_r <= cfg_wdata[SiteW-1:0];
        default: ;
      endcase
    end
  end

  // site counter, a zero length ends every site
  always_comb begin
    site_inc = {1'b0, site_r} + 1'b1;
    if (site_inc >= {1'b0, blen_r}) begin
      be_nxt   = 1'b1;
      site_nxt = '0;
    end else begin
      be_nxt   = 1'b0;
      site_nxt = site_inc[SiteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_r <= '0;
    end else if (accept) begin
      site_r <= site_nxt;
    end
  end

  // pick link elements per lane, transposed when conjugating
  always_comb begin
    lk[0] = in_data.link_00; lk[1] = in_data.link_01; lk[2] = in_data.link_02;
    lk[3] = in_data.link_10; lk[4] = in_data.link_11; lk[5] = in_data.link_12;
    lk[6] = in_data.link_20; lk[7] = in_data.link_21; lk[8] = in_data.link_22;
    vw[0] = in_data.vec_0;   vw[1] = in_data.vec_1;   vw[2] = in_data.vec_2;
    for (int d = 0; d < 3; d++) begin
      for (int k = 0; k < 3; k++) begin
        if (conj_r) begin
          sel_re_nxt[d][k] = lk[k*3+d][32+CW-1:32];
          sel_im_nxt[d][k] = lk[k*3+d][CW-1:0];
        end else begin
          sel_re_nxt[d][k] = lk[d*3+k][32+CW-1:32];
          sel_im_nxt[d][k] = lk[d*3+k][CW-1:0];
        end
      end
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_conj_r <= conj_r;
      for (int d = 0; d < 3; d++) begin
        vr_r[d] <= vw[d][32+CW-1:32];
        vi_r[d] <= vw[d][CW-1:0];
        for (int k = 0; k < 3; k++) begin
          lr_r[d][k] <= sel_re_nxt[d][k];
          li_r[d][k] <= sel_im_nxt[d][k];
        end
      end
    end
  end

  // one lane per result component
  for (genvar d = 0; d < 3; d++) begin : g_lane
    su3mv_lane #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .conj   (s1_conj_r),
      .lnk_re (lr_r[d]),
      .lnk_im (li_r[d]),
      .vec_re (vr_r),
      .vec_im (vi_r),
      .sum_re (sum_re[d]),
      .sum_im (sum_im[d])
    );
  end

  // merge lanes into the output register
  su3mv_sat #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_sat (
    .clk       (clk),
    .ctrl      (ctrl),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .batch_end (be_r[NStg-2]),
    .out_data  (out_data)
  );

endmodule

// ----- src/su3mv_lane.sv -----
// su3mv_lane: one result component, three complex products summed at full width
// stages: products, per-column complex terms, three-term sum
// depends on su3mv_pkg
module su3mv_lane
  import su3mv_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                                 clk,
  input  su3mv_ctrl_t                          ctrl,
  input  logic                                 conj,
  input  logic signed [COMPONENT_WIDTH-1:0]    lnk_re [3],
  input  logic signed [COMPONENT_WIDTH-1:0]    lnk_im [3],
  input  logic signed [COMPONENT_WIDTH-1:0]    vec_re [3],
  input  logic signed [COMPONENT_WIDTH-1:0]    vec_im [3],
  output logic signed [2*COMPONENT_WIDTH+2:0]  sum_re,
  output logic signed [2*COMPONENT_WIDTH+2:0]  sum_im
);

  localparam int PW   = 2 * COMPONENT_WIDTH;
  localparam int TW   = PW + 1;
  localparam int AccW = PW + 3;

  logic signed [PW-1:0]   p_rr_r [3];
  logic signed [PW-1:0]   p_ii_r [3];
  logic signed [PW-1:0]   p_ri_r [3];
  logic signed [PW-1:0]   p_ir_r [3];
  logic                   conj_r;
  logic signed [TW-1:0]   t_re_r [3];
  logic signed [TW-1:0]   t_im_r [3];
  logic signed [AccW-1:0] sum_re_r;
  logic signed [AccW-1:0] sum_im_r;

  // stage 2: four real products per column
  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      conj_r <= conj;
      for (int k = 0; k < 3; k++) begin
        p_rr_r[k] <= lnk_re[k] * vec_re[k];
        p_ii_r[k] <= lnk_im[k] * vec_im[k];
        p_ri_r[k] <= lnk_re[k] * vec_im[k];
        p_ir_r[k] <= lnk_im[k] * vec_re[k];
      end
    end
  end

  // stage 3: complex product per column, conjugating the link if asked
  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      for (int k = 0; k < 3; k++) begin
        if (conj_r) begin
          t_re_r[k] <= TW'(p_rr_r[k]) + TW'(p_ii_r[k]);
          t_im_r[k] <= TW'(p_ri_r[k]) - TW'(p_ir_r[k]);
        end else begin
          t_re_r[k] <= TW'(p_rr_r[k]) - TW'(p_ii_r[k]);
          t_im_r[k] <= TW'(p_ri_r[k]) + TW'(p_ir_r[k]);
        end
      end
    end
  end

  // stage 4: sum over the three columns
  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      sum_re_r <= AccW'(t_re_r[0]) + AccW'(t_re_r[1]) + AccW'(t_re_r[2]);
      sum_im_r <= AccW'(t_im_r[0]) + AccW'(t_im_r[1]) + AccW'(t_im_r[2]);
    end
  end

  assign sum_re = sum_re_r;
  assign sum_im = sum_im_r;

endmodule

// ----- src/su3mv_sat.sv -----
// su3mv_sat: merges the three lanes, rescales, saturates and packs the result item
// holds the output register
// depends on su3mv_pkg
module su3mv_sat
  import su3mv_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS   = 28
) (
  input  logic                                clk,
  input  su3mv_ctrl_t                         ctrl,
  input  logic signed [2*COMPONENT_WIDTH+2:0] sum_re [3],
  input  logic signed [2*COMPONENT_WIDTH+2:0] sum_im [3],
  input  logic                                batch_end,
  output su3mv_out_t                          out_data
);

  localparam int AccW = 2 * COMPONENT_WIDTH + 3;
  localparam logic signed [AccW-1:0] SatMax =
    AccW'((64'sd1 <<< (COMPONENT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0] SatMin = ~SatMax;

  su3mv_out_t  res_r;
  su3mv_out_t  res_nxt;
  logic [31:0] re_w [3];
  logic [31:0] im_w [3];

  function automatic logic [31:0] rescale(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0]            sh;
    logic signed [COMPONENT_WIDTH-1:0] clip;
    sh = s >>> FRACTION_BITS;
    if (sh > SatMax) begin
      clip = SatMax[COMPONENT_WIDTH-1:0];
    end else if (sh < SatMin) begin
      clip = SatMin[COMPONENT_WIDTH-1:0];
    end else begin
      clip = sh[COMPONENT_WIDTH-1:0];
    end
    return 32'(clip);
  endfunction

  // rescale each lane and pack real over imag
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      re_w[d] = rescale(sum_re[d]);
      im_w[d] = rescale(sum_im[d]);
    end
    res_nxt.res_0     = {re_w[0], im_w[0]};
    res_nxt.res_1     = {re_w[1], im_w[1]};
    res_nxt.res_2     = {re_w[2], im_w[2]};
    res_nxt.batch_end = batch_end;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.en5) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule
